[rtl/smi_pkg.sv]
// Shared constants and types for the small matrix inverse block.
package smi_pkg;

   localparam int DEF_ELEMENT_WIDTH = 16;
   localparam int DEF_FRACTION_BITS = 12;
   localparam int OUT_W             = 32;
   localparam int OUT_FRAC          = 16;
   localparam int QB                = OUT_W + 1;
   localparam int N_LANES           = 9;
   localparam int FRONT_STAGES      = 4;
   localparam int LANE_STAGES       = QB + 1;
   localparam logic [1:0] DIM_3X3   = 2'd3;

   typedef logic signed [OUT_W-1:0] out_type;

   typedef struct packed {
      logic singular;
      logic three;
   } mctl_type;

endpackage

[rtl/smi_front.sv]
// Front end: cofactors, determinant, magnitudes and rounded determinant.
module smi_front #(
   parameter int E = smi_pkg::DEF_ELEMENT_WIDTH,
   parameter int F = smi_pkg::DEF_FRACTION_BITS,
   localparam int AW = 2 * E + 1,
   localparam int DW = 3 * E + 3
) (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [1:0]            dim,
   input  logic signed [E-1:0]   m [3][3],
   output logic [AW-1:0]         amag [smi_pkg::N_LANES],
   output logic                  aneg [smi_pkg::N_LANES],
   output logic [DW-1:0]         dmag,
   output logic                  dneg,
   output logic signed [DW:0]    drnd,
   output smi_pkg::mctl_type     ctl
);
   import smi_pkg::*;

   localparam int PW = E + AW;
   localparam logic signed [DW:0] ONE = (DW+1)'(1);
   localparam logic signed [DW:0] H3  = ONE <<< (2 * F - 1);
   localparam logic signed [DW:0] H2  = ONE <<< (F - 1);
   localparam logic signed [DW:0] H3M = H3 - ONE;
   localparam logic signed [DW:0] H2M = H2 - ONE;

   logic signed [AW-1:0] adj_in   [N_LANES];
   logic signed [AW-1:0] adj1_ff  [N_LANES];
   logic signed [AW-1:0] adj2_ff  [N_LANES];
   logic signed [AW-1:0] adj3_ff  [N_LANES];
   logic signed [E-1:0]  m0_ff    [3];
   logic signed [PW-1:0] p_ff     [3];
   logic signed [AW-1:0] det2_in;
   logic signed [AW-1:0] det2a_ff, det2b_ff;
   logic signed [DW-1:0] det_ff;
   logic                 three_in;
   logic                 three1_ff, three2_ff, three3_ff;
   logic signed [DW:0]   dsum;
   logic signed [DW:0]   dadd;

   assign three_in = (dim == DIM_3X3);

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int S = (j + 1) % 3;
         localparam int T = (j + 2) % 3;
         localparam int U = (i + 1) % 3;
         localparam int V = (i + 2) % 3;
         logic signed [AW-1:0] c3;
         logic signed [AW-1:0] c2;
         assign c3 = AW'(m[S][U]) * AW'(m[T][V]) - AW'(m[T][U]) * AW'(m[S][V]);
         if (i == 0 && j == 0) begin : g_a
            assign c2 = AW'(m[1][1]);
         end else if (i == 0 && j == 1) begin : g_b
            assign c2 = -AW'(m[0][1]);
         end else if (i == 1 && j == 0) begin : g_c
            assign c2 = -AW'(m[1][0]);
         end else if (i == 1 && j == 1) begin : g_d
            assign c2 = AW'(m[0][0]);
         end else begin : g_z
            assign c2 = '0;
         end
         assign adj_in[i*3+j] = three_in ? c3 : c2;
      end
   end

   assign det2_in = AW'(m[0][0]) * AW'(m[1][1]) - AW'(m[0][1]) * AW'(m[1][0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         adj1_ff   <= adj_in;
         m0_ff     <= m[0];
         det2a_ff  <= det2_in;
         three1_ff <= three_in;
         for (int j = 0; j < 3; j++) begin
            p_ff[j] <= PW'(m0_ff[j]) * PW'(adj1_ff[j*3]);
         end
         adj2_ff   <= adj1_ff;
         det2b_ff  <= det2a_ff;
         three2_ff <= three1_ff;
         det_ff    <= three2_ff ? DW'(p_ff[0]) + DW'(p_ff[1]) + DW'(p_ff[2])
                                : DW'(det2b_ff);
         adj3_ff   <= adj2_ff;
         three3_ff <= three2_ff;
      end
   end

   always_comb begin
      if (three3_ff) begin
         dadd = det_ff[DW-1] ? H3M : H3;
      end else begin
         dadd = det_ff[DW-1] ? H2M : H2;
      end
      dsum = (DW+1)'(det_ff) + dadd;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N_LANES; k++) begin
            amag[k] <= adj3_ff[k][AW-1] ? AW'(-adj3_ff[k]) : AW'(adj3_ff[k]);
            aneg[k] <= adj3_ff[k][AW-1];
         end
         dmag         <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         dneg         <= det_ff[DW-1];
         drnd         <= three3_ff ? (dsum >>> (2 * F)) : (dsum >>> F);
         ctl.singular <= (det_ff == '0);
         ctl.three    <= three3_ff;
      end
   end

endmodule

[rtl/smi_lane.sv]
// One inverse element: rounded restoring divide, one quotient bit per stage.
module smi_lane #(
   parameter int AW = 2 * smi_pkg::DEF_ELEMENT_WIDTH + 1,
   parameter int DW = 3 * smi_pkg::DEF_ELEMENT_WIDTH + 3,
   parameter int F  = smi_pkg::DEF_FRACTION_BITS
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [AW-1:0]     amag,
   input  logic              aneg,
   input  logic [DW-1:0]     dmag,
   input  logic              dneg,
   input  logic              used,
   output smi_pkg::out_type  res
);
   import smi_pkg::*;

   localparam int K   = OUT_FRAC + F;
   localparam int NA  = AW + K + 1;
   localparam int NW  = ((NA > DW) ? NA : DW) + 1;
   localparam int DDW = DW + 1;
   localparam int SW0 = DDW + QB - 1;
   localparam int SW  = (NW > SW0) ? NW : SW0;
   localparam logic [QB-1:0] LIM = QB'(1) << (OUT_W - 1);
   localparam out_type OMAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam out_type OMIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic [SW-1:0]  r_ff    [QB];
   logic [DDW-1:0] d_ff    [QB];
   logic [QB-1:0]  q_ff    [QB];
   logic           neg_ff  [QB+1];
   logic           zero_ff [QB+1];
   logic [QB-1:0]  q;
   logic [QB-1:0]  qn;

   // numerator 2|a|<<K + |d|, divisor 2|d|: quotient is rounded half up
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0]    <= SW'(NW'(amag) << (K + 1)) + SW'(dmag);
         d_ff[0]    <= {dmag, 1'b0};
         neg_ff[0]  <= aneg ^ dneg;
         zero_ff[0] <= !used || (dmag == '0);
      end
   end

   for (genvar st = 0; st < QB; st++) begin : g_step
      localparam int B = QB - 1 - st;
      logic [SW-1:0] trial;
      logic          ge;
      logic [QB-1:0] q_prev;

      assign trial = SW'(d_ff[st]) << B;
      assign ge    = (r_ff[st] >= trial);
      if (st == 0) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[st-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[st]      <= q_prev | (ge ? (QB'(1) << B) : '0);
            neg_ff[st+1]  <= neg_ff[st];
            zero_ff[st+1] <= zero_ff[st];
         end
      end

      if (st + 1 < QB) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               r_ff[st+1] <= ge ? r_ff[st] - trial : r_ff[st];
               d_ff[st+1] <= d_ff[st];
            end
         end
      end
   end

   assign q  = q_ff[QB-1];
   assign qn = ~q + QB'(1);

   always_comb begin
      if (zero_ff[QB]) begin
         res = '0;
      end else if (neg_ff[QB]) begin
         res = (q > LIM) ? OMIN : out_type'(qn[OUT_W-1:0]);
      end else begin
         res = (q >= LIM) ? OMAX : out_type'(q[OUT_W-1:0]);
      end
   end

endmodule

[rtl/smi_merge.sv]
// Merge stage: aligns determinant with the lanes and holds the output register.
module smi_merge #(
   parameter int DW = 3 * smi_pkg::DEF_ELEMENT_WIDTH + 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  smi_pkg::mctl_type  ctl,
   input  logic signed [DW:0] drnd,
   input  smi_pkg::out_type   lane_res [smi_pkg::N_LANES],
   input  logic               rsp_stall,
   output logic               adv,
   output logic               rsp_valid,
   output smi_pkg::out_type   rsp_determinant,
   output logic               rsp_singular,
   output smi_pkg::out_type   rsp_r [smi_pkg::N_LANES]
);
   import smi_pkg::*;

   localparam logic signed [DW:0] SMAX = (DW+1)'($signed({1'b0, {(OUT_W-1){1'b1}}}));
   localparam logic signed [DW:0] SMIN = (DW+1)'($signed({1'b1, {(OUT_W-1){1'b0}}}));

   logic signed [DW:0] drnd_ff [LANE_STAGES];
   mctl_type           ctl_ff  [LANE_STAGES];
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [DW:0] dlast;
   out_type            det_in;

   assign adv          = !(rsp_valid_ff && rsp_stall);
   assign rsp_valid_in = adv ? in_valid : rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign dlast        = drnd_ff[LANE_STAGES-1];

   always_comb begin
      if (dlast > SMAX) begin
         det_in = out_type'(SMAX[OUT_W-1:0]);
      end else if (dlast < SMIN) begin
         det_in = out_type'(SMIN[OUT_W-1:0]);
      end else begin
         det_in = out_type'(dlast[OUT_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         drnd_ff[0] <= drnd;
         ctl_ff[0]  <= ctl;
         for (int k = 1; k < LANE_STAGES; k++) begin
            drnd_ff[k] <= drnd_ff[k-1];
            ctl_ff[k]  <= ctl_ff[k-1];
         end
         rsp_determinant <= det_in;
         rsp_singular    <= ctl_ff[LANE_STAGES-1].singular;
         rsp_r           <= lane_res;
      end
   end

endmodule

[rtl/small_matrix_inverse.sv]
// Small matrix inverse top level: front end, nine divider lanes, merge stage.
//
// One 2x2 or 3x3 matrix per request on the req_ channel (dim 3 selects 3x3,
// any other code 2x2), signed Q3.12 elements. Each request yields exactly one
// response on rsp_: the Q19.12 determinant, a singular flag and the Q15.16
// inverse, saturated to 32 bits; unused 2x2 positions and singular inverses
// are zero.
// From acceptance to rsp_valid a request passes four front-end stages
// (cofactor products, determinant products, determinant sum, magnitudes),
// 34 lane stages (one set-up stage plus a 33-stage restoring divider that
// resolves one quotient bit per stage) and the output register.
// Throughput is one request per cycle; the nine lanes work side by side.
// The whole pipeline advances on one enable: while a response is held with
// rsp_stall high, req_stall is high and nothing moves. Otherwise a request
// is taken every cycle, including while the output register refills.
// Synchronous reset clears all valid flags; payload registers are not reset.
module small_matrix_inverse #(
   parameter int ELEMENT_WIDTH = smi_pkg::DEF_ELEMENT_WIDTH,
   parameter int FRACTION_BITS = smi_pkg::DEF_FRACTION_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_dim,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m00,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m01,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m02,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m10,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m11,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m12,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m20,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m21,
   input  logic signed [ELEMENT_WIDTH-1:0] req_m22,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output smi_pkg::out_type               rsp_determinant,
   output logic                           rsp_singular,
   output smi_pkg::out_type               rsp_r00,
   output smi_pkg::out_type               rsp_r01,
   output smi_pkg::out_type               rsp_r02,
   output smi_pkg::out_type               rsp_r10,
   output smi_pkg::out_type               rsp_r11,
   output smi_pkg::out_type               rsp_r12,
   output smi_pkg::out_type               rsp_r20,
   output smi_pkg::out_type               rsp_r21,
   output smi_pkg::out_type               rsp_r22
);
   import smi_pkg::*;

   localparam int AW    = 2 * ELEMENT_WIDTH + 1;
   localparam int DW    = 3 * ELEMENT_WIDTH + 3;
   localparam int VSTGS = FRONT_STAGES + LANE_STAGES;

   logic                            adv;
   logic signed [ELEMENT_WIDTH-1:0] m [3][3];
   logic [AW-1:0]                   amag [N_LANES];
   logic                            aneg [N_LANES];
   logic [DW-1:0]                   dmag;
   logic                            dneg;
   logic signed [DW:0]              drnd;
   mctl_type                        ctl;
   out_type                         lane_res [N_LANES];
   out_type                         rsp_r [N_LANES];
   logic [VSTGS-1:0]                v_ff, v_in;

   assign req_stall = !adv;

   assign m[0][0] = req_m00;
   assign m[0][1] = req_m01;
   assign m[0][2] = req_m02;
   assign m[1][0] = req_m10;
   assign m[1][1] = req_m11;
   assign m[1][2] = req_m12;
   assign m[2][0] = req_m20;
   assign m[2][1] = req_m21;
   assign m[2][2] = req_m22;

   assign v_in = adv ? {v_ff[VSTGS-2:0], req_valid} : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   smi_front #(
      .E (ELEMENT_WIDTH),
      .F (FRACTION_BITS)
   ) u_front (
      .clock (clock),
      .adv   (adv),
      .dim   (req_dim),
      .m     (m),
      .amag  (amag),
      .aneg  (aneg),
      .dmag  (dmag),
      .dneg  (dneg),
      .drnd  (drnd),
      .ctl   (ctl)
   );

   for (genvar i = 0; i < N_LANES; i++) begin : g_lane
      localparam int ROW = i / 3;
      localparam int COL = i % 3;
      logic used;
      assign used = ctl.three || (ROW < 2 && COL < 2);

      smi_lane #(
         .AW (AW),
         .DW (DW),
         .F  (FRACTION_BITS)
      ) u_lane (
         .clock (clock),
         .adv   (adv),
         .amag  (amag[i]),
         .aneg  (aneg[i]),
         .dmag  (dmag),
         .dneg  (dneg),
         .used  (used),
         .res   (lane_res[i])
      );
   end

   smi_merge #(
      .DW (DW)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (v_ff[VSTGS-1]),
      .ctl             (ctl),
      .drnd            (drnd),
      .lane_res        (lane_res),
      .rsp_stall       (rsp_stall),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_determinant (rsp_determinant),
      .rsp_singular    (rsp_singular),
      .rsp_r           (rsp_r)
   );

   assign rsp_r00 = rsp_r[0];
   assign rsp_r01 = rsp_r[1];
   assign rsp_r02 = rsp_r[2];
   assign rsp_r10 = rsp_r[3];
   assign rsp_r11 = rsp_r[4];
   assign rsp_r12 = rsp_r[5];
   assign rsp_r20 = rsp_r[6];
   assign rsp_r21 = rsp_r[7];
   assign rsp_r22 = rsp_r[8];

endmodule

[rtl/smi_checker.sv]
// Port-level checks for the small matrix inverse, bound to the top level.
module smi_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input smi_pkg::out_type rsp_determinant,
   input logic             rsp_singular,
   input smi_pkg::out_type rsp_r00,
   input smi_pkg::out_type rsp_r01,
   input smi_pkg::out_type rsp_r02,
   input smi_pkg::out_type rsp_r10,
   input smi_pkg::out_type rsp_r11,
   input smi_pkg::out_type rsp_r12,
   input smi_pkg::out_type rsp_r20,
   input smi_pkg::out_type rsp_r21,
   input smi_pkg::out_type rsp_r22
);

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_determinant == '0 &&
         rsp_r00 == '0 && rsp_r01 == '0 && rsp_r02 == '0 &&
         rsp_r10 == '0 && rsp_r11 == '0 && rsp_r12 == '0 &&
         rsp_r20 == '0 && rsp_r21 == '0 && rsp_r22 == '0)
      else $error("singular response with nonzero fields");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_determinant) &&
         $stable(rsp_r00) && $stable(rsp_r22))
      else $error("stalled response changed");

endmodule

bind small_matrix_inverse smi_checker u_smi_checker (.*);
